>>> design/obpf_pkg.sv
// obpf_pkg: shared register map for the oriented box point filter
// no dependencies; imported by every module of the block

package obpf_pkg;

    // configuration register index width and count
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_REG_COUNT  = 8;

    // configuration register indexes, in register-map order
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CENTER_X   = 3'd0,
        REG_CENTER_Y   = 3'd1,
        REG_CENTER_Z   = 3'd2,
        REG_BOX_LENGTH = 3'd3,
        REG_BOX_WIDTH  = 3'd4,
        REG_BOX_HEIGHT = 3'd5,
        REG_YAW_SINE   = 3'd6,
        REG_YAW_COSINE = 3'd7
    } cfg_reg_t;

endpackage

>>> design/obpf_cfg.sv
// obpf_cfg: box configuration registers and derived footprint limits
// depends on obpf_pkg; limits are r*length and r*width with r = s*s + c*c

module obpf_cfg #(
    parameter int COORD_BITS     = 32,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [obpf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]             cfg_data,
    output logic signed [COORD_BITS-1:0]      center_x,
    output logic signed [COORD_BITS-1:0]      center_y,
    output logic signed [COORD_BITS-1:0]      center_z,
    output logic [COORD_BITS-2:0]             box_height,
    output logic signed [TRIG_FRAC_BITS+1:0]  yaw_sine,
    output logic signed [TRIG_FRAC_BITS+1:0]  yaw_cosine,
    output logic [2*TRIG_FRAC_BITS+COORD_BITS+2:0] len_lim,
    output logic [2*TRIG_FRAC_BITS+COORD_BITS+2:0] wid_lim,
    output logic                              len_nonzero,
    output logic                              wid_nonzero
);
    import obpf_pkg::*;

    localparam int TB = TRIG_FRAC_BITS + 2;
    localparam int DB = COORD_BITS - 1;
    localparam int RW = 2 * TB;
    localparam int LW = RW + DB;

    logic signed [COORD_BITS-1:0] center_x_reg, center_x_next;
    logic signed [COORD_BITS-1:0] center_y_reg, center_y_next;
    logic signed [COORD_BITS-1:0] center_z_reg, center_z_next;
    logic [DB-1:0]                box_length_reg, box_length_next;
    logic [DB-1:0]                box_width_reg, box_width_next;
    logic [DB-1:0]                box_height_reg, box_height_next;
    logic signed [TB-1:0]         yaw_sine_reg, yaw_sine_next;
    logic signed [TB-1:0]         yaw_cosine_reg, yaw_cosine_next;
    logic signed [RW-1:0]         sine_sq;
    logic signed [RW-1:0]         cosine_sq;
    logic [RW-1:0]                r_reg, r_next;
    logic [LW-1:0]                len_lim_reg, len_lim_next;
    logic [LW-1:0]                wid_lim_reg, wid_lim_next;

    // register write decode
    always_comb begin
        center_x_next   = center_x_reg;
        center_y_next   = center_y_reg;
        center_z_next   = center_z_reg;
        box_length_next = box_length_reg;
        box_width_next  = box_width_reg;
        box_height_next = box_height_reg;
        yaw_sine_next   = yaw_sine_reg;
        yaw_cosine_next = yaw_cosine_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:   center_x_next   = $signed(cfg_data);
                REG_CENTER_Y:   center_y_next   = $signed(cfg_data);
                REG_CENTER_Z:   center_z_next   = $signed(cfg_data);
                REG_BOX_LENGTH: box_length_next = cfg_data[DB-1:0];
                REG_BOX_WIDTH:  box_width_next  = cfg_data[DB-1:0];
                REG_BOX_HEIGHT: box_height_next = cfg_data[DB-1:0];
                REG_YAW_SINE:   yaw_sine_next   = $signed(cfg_data[TB-1:0]);
                REG_YAW_COSINE: yaw_cosine_next = $signed(cfg_data[TB-1:0]);
                default: ;
            endcase
        end
    end

    // squared trig magnitude, then the two footprint limits
    assign sine_sq      = RW'(yaw_sine_reg) * RW'(yaw_sine_reg);
    assign cosine_sq    = RW'(yaw_cosine_reg) * RW'(yaw_cosine_reg);
    assign r_next       = $unsigned(sine_sq) + $unsigned(cosine_sq);
    assign len_lim_next = LW'(r_reg) * LW'(box_length_reg);
    assign wid_lim_next = LW'(r_reg) * LW'(box_width_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
            box_length_reg <= '0;
            box_width_reg  <= '0;
            box_height_reg <= '0;
            yaw_sine_reg   <= '0;
            yaw_cosine_reg <= TB'(1) << TRIG_FRAC_BITS;
            r_reg          <= RW'(1) << (2 * TRIG_FRAC_BITS);
            len_lim_reg    <= '0;
            wid_lim_reg    <= '0;
        end else begin
            center_x_reg   <= center_x_next;
            center_y_reg   <= center_y_next;
            center_z_reg   <= center_z_next;
            box_length_reg <= box_length_next;
            box_width_reg  <= box_width_next;
            box_height_reg <= box_height_next;
            yaw_sine_reg   <= yaw_sine_next;
            yaw_cosine_reg <= yaw_cosine_next;
            r_reg          <= r_next;
            len_lim_reg    <= len_lim_next;
            wid_lim_reg    <= wid_lim_next;
        end
    end

    assign center_x    = center_x_reg;
    assign center_y    = center_y_reg;
    assign center_z    = center_z_reg;
    assign box_height  = box_height_reg;
    assign yaw_sine    = yaw_sine_reg;
    assign yaw_cosine  = yaw_cosine_reg;
    assign len_lim     = len_lim_reg;
    assign wid_lim     = wid_lim_reg;
    assign len_nonzero = (box_length_reg != '0);
    assign wid_nonzero = (box_width_reg != '0);

endmodule

>>> design/obpf_rotate.sv
// obpf_rotate: input register, offset from box center, rotation products
// depends on obpf_pkg; feeds obpf_classify through a valid/ready stage

module obpf_rotate #(
    parameter int COORD_BITS     = 32,
    parameter int TRIG_FRAC_BITS = 14,
    parameter int INDEX_BITS     = 20
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic signed [COORD_BITS-1:0]               point_x,
    input  logic signed [COORD_BITS-1:0]               point_y,
    input  logic signed [COORD_BITS-1:0]               point_z,
    input  logic [INDEX_BITS-1:0]                      point_index,
    input  logic signed [COORD_BITS-1:0]               center_x,
    input  logic signed [COORD_BITS-1:0]               center_y,
    input  logic signed [COORD_BITS-1:0]               center_z,
    input  logic signed [TRIG_FRAC_BITS+1:0]           yaw_sine,
    input  logic signed [TRIG_FRAC_BITS+1:0]           yaw_cosine,
    output logic                                       prod_valid,
    input  logic                                       prod_ready,
    output logic signed [TRIG_FRAC_BITS+COORD_BITS+2:0] c_dx,
    output logic signed [TRIG_FRAC_BITS+COORD_BITS+2:0] s_dy,
    output logic signed [TRIG_FRAC_BITS+COORD_BITS+2:0] c_dy,
    output logic signed [TRIG_FRAC_BITS+COORD_BITS+2:0] s_dx,
    output logic signed [COORD_BITS:0]                 dz,
    output logic [INDEX_BITS-1:0]                      prod_index
);
    import obpf_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = TRIG_FRAC_BITS + 2 + DW;

    logic                         in_valid_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic [INDEX_BITS-1:0]        in_index_reg;

    logic                 d_valid_reg;
    logic signed [DW-1:0] dx_reg, dx_next;
    logic signed [DW-1:0] dy_reg, dy_next;
    logic signed [DW-1:0] dz_reg, dz_next;
    logic [INDEX_BITS-1:0] d_index_reg;

    logic                  p_valid_reg;
    logic signed [PW-1:0]  c_dx_reg, c_dx_next;
    logic signed [PW-1:0]  s_dy_reg, s_dy_next;
    logic signed [PW-1:0]  c_dy_reg, c_dy_next;
    logic signed [PW-1:0]  s_dx_reg, s_dx_next;
    logic signed [DW-1:0]  p_dz_reg;
    logic [INDEX_BITS-1:0] p_index_reg;

    logic adv_in, adv_d, adv_p;

    // each stage moves when it is empty or the next one moves
    assign adv_p    = !p_valid_reg || prod_ready;
    assign adv_d    = !d_valid_reg || adv_p;
    assign adv_in   = !in_valid_reg || adv_d;
    assign in_ready = adv_in;

    // offsets from box center
    assign dx_next = DW'(px_reg) - DW'(center_x);
    assign dy_next = DW'(py_reg) - DW'(center_y);
    assign dz_next = DW'(pz_reg) - DW'(center_z);

    // rotation products, one multiplier each
    assign c_dx_next = PW'(yaw_cosine) * PW'(dx_reg);
    assign s_dy_next = PW'(yaw_sine) * PW'(dy_reg);
    assign c_dy_next = PW'(yaw_cosine) * PW'(dy_reg);
    assign s_dx_next = PW'(yaw_sine) * PW'(dx_reg);

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            d_valid_reg  <= 1'b0;
            p_valid_reg  <= 1'b0;
        end else begin
            if (adv_in) begin
                in_valid_reg <= in_valid;
            end
            if (adv_d) begin
                d_valid_reg <= in_valid_reg;
            end
            if (adv_p) begin
                p_valid_reg <= d_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (adv_in && in_valid) begin
            px_reg       <= point_x;
            py_reg       <= point_y;
            pz_reg       <= point_z;
            in_index_reg <= point_index;
        end
        if (adv_d && in_valid_reg) begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            dz_reg      <= dz_next;
            d_index_reg <= in_index_reg;
        end
        if (adv_p && d_valid_reg) begin
            c_dx_reg    <= c_dx_next;
            s_dy_reg    <= s_dy_next;
            c_dy_reg    <= c_dy_next;
            s_dx_reg    <= s_dx_next;
            p_dz_reg    <= dz_reg;
            p_index_reg <= d_index_reg;
        end
    end

    assign prod_valid = p_valid_reg;
    assign c_dx       = c_dx_reg;
    assign s_dy       = s_dy_reg;
    assign c_dy       = c_dy_reg;
    assign s_dx       = s_dx_reg;
    assign dz         = p_dz_reg;
    assign prod_index = p_index_reg;

endmodule

>>> design/obpf_classify.sv
// obpf_classify: footprint and height tests, result register
// depends on obpf_pkg; takes products from obpf_rotate, limits from obpf_cfg

module obpf_classify #(
    parameter int COORD_BITS     = 32,
    parameter int TRIG_FRAC_BITS = 14,
    parameter int INDEX_BITS     = 20
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        prod_valid,
    output logic                                        prod_ready,
    input  logic signed [TRIG_FRAC_BITS+COORD_BITS+2:0] c_dx,
    input  logic signed [TRIG_FRAC_BITS+COORD_BITS+2:0] s_dy,
    input  logic signed [TRIG_FRAC_BITS+COORD_BITS+2:0] c_dy,
    input  logic signed [TRIG_FRAC_BITS+COORD_BITS+2:0] s_dx,
    input  logic signed [COORD_BITS:0]                  dz,
    input  logic [INDEX_BITS-1:0]                       prod_index,
    input  logic [COORD_BITS-2:0]                       box_height,
    input  logic [2*TRIG_FRAC_BITS+COORD_BITS+2:0]      len_lim,
    input  logic [2*TRIG_FRAC_BITS+COORD_BITS+2:0]      wid_lim,
    input  logic                                        len_nonzero,
    input  logic                                        wid_nonzero,
    output logic                                        res_valid,
    input  logic                                        res_ready,
    output logic [INDEX_BITS-1:0]                       index_out,
    output logic                                        in_box
);
    import obpf_pkg::*;

    localparam int PW = TRIG_FRAC_BITS + COORD_BITS + 3;
    localparam int SW = PW + 1;
    localparam int CW = SW + TRIG_FRAC_BITS + 1;
    localparam int ZW = COORD_BITS + 2;

    logic signed [SW-1:0] u_val, v_val;
    logic [SW-1:0]        u_mag, v_mag;
    logic [CW-1:0]        u_scaled, v_scaled;
    logic                 u_ok, v_ok, z_ok;
    logic signed [ZW-1:0] dz_twice, h_pos, h_neg;

    logic                  res_valid_reg;
    logic [INDEX_BITS-1:0] index_reg;
    logic                  in_box_reg, in_box_next;
    logic                  adv;

    // rotated offsets and their magnitudes
    assign u_val = SW'(c_dx) + SW'(s_dy);
    assign v_val = SW'(c_dy) - SW'(s_dx);
    assign u_mag = u_val[SW-1] ? $unsigned(-u_val) : $unsigned(u_val);
    assign v_mag = v_val[SW-1] ? $unsigned(-v_val) : $unsigned(v_val);
    assign u_scaled = {u_mag, (TRIG_FRAC_BITS+1)'(0)};
    assign v_scaled = {v_mag, (TRIG_FRAC_BITS+1)'(0)};

    // footprint tests, each trivially true when the other extent is zero
    assign u_ok = !wid_nonzero || (u_scaled <= CW'(len_lim));
    assign v_ok = !len_nonzero || (v_scaled <= CW'(wid_lim));

    // height test, strict at floor and top
    assign dz_twice = {dz, 1'b0};
    assign h_pos    = $signed({3'b000, box_height});
    assign h_neg    = -h_pos;
    assign z_ok     = (dz_twice > h_neg) && (dz_twice < h_pos);

    assign in_box_next = u_ok && v_ok && z_ok;

    // output register, refilled whenever it is empty or being taken
    assign adv        = !res_valid_reg || res_ready;
    assign prod_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (adv) begin
            res_valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && prod_valid) begin
            index_reg  <= prod_index;
            in_box_reg <= in_box_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign index_out = index_reg;
    assign in_box    = in_box_reg;

endmodule

>>> design/oriented_box_point_filter.sv
// oriented_box_point_filter: top level, point-in-yaw-rotated-box classifier
// depends on obpf_pkg, obpf_cfg, obpf_rotate and obpf_classify
//
// Usage:
//   Each request on the s_ channel carries one point (x, y, z in signed
//   Q16.16) and its index. For every request exactly one result leaves on
//   the m_ channel, in order: the index and a flag that is 1 when the point
//   lies inside the configured box.
//   The box is set through the write port (cfg_we, cfg_index, cfg_data):
//   center, length, width, height and the sine and cosine of its yaw.
//   Write it only while no request is in flight; the derived footprint
//   limits are registered after the last write, the yaw terms by way of r_reg.
//   Throughput is one request per cycle while m_tready does not stall the
//   pipe. A request passes the input register, center offset, rotation
//   products, then the test and the result register.
//   A stalled m_tready backs up the four-stage pipe stage by stage; the
//   input keeps accepting while any stage is empty.
//   Reset (aresetn low, synchronous) empties the pipe, clears every box
//   register and sets the cosine to 1.0.

module oriented_box_point_filter #(
    parameter int COORD_BITS     = 32,
    parameter int TRIG_FRAC_BITS = 14,
    parameter int INDEX_BITS     = 20
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // point_x, point_y, point_z, point_index, zero pad
    input  logic [((3*COORD_BITS+INDEX_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // index_out, in_box, zero pad
    output logic [((INDEX_BITS+1+7)/8)*8-1:0]            m_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    input  logic                                        cfg_we,
    input  logic [obpf_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
    input  logic [COORD_BITS-1:0]                        cfg_data
);
    import obpf_pkg::*;

    localparam int TB    = TRIG_FRAC_BITS + 2;
    localparam int PW    = TB + COORD_BITS + 1;
    localparam int LW    = 2 * TB + COORD_BITS - 1;
    localparam int OUT_W = ((INDEX_BITS + 1 + 7) / 8) * 8;

    logic signed [COORD_BITS-1:0] point_x, point_y, point_z;
    logic [INDEX_BITS-1:0]        point_index;

    logic signed [COORD_BITS-1:0] center_x, center_y, center_z;
    logic [COORD_BITS-2:0]        box_height;
    logic signed [TB-1:0]         yaw_sine, yaw_cosine;
    logic [LW-1:0]                len_lim, wid_lim;
    logic                         len_nonzero, wid_nonzero;

    logic                         prod_valid, prod_ready;
    logic signed [PW-1:0]         c_dx, s_dy, c_dy, s_dx;
    logic signed [COORD_BITS:0]   dz;
    logic [INDEX_BITS-1:0]        prod_index;

    logic [INDEX_BITS-1:0]        index_out;
    logic                         in_box;

    // unpack the request
    assign point_x     = $signed(s_tdata[COORD_BITS-1:0]);
    assign point_y     = $signed(s_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign point_z     = $signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
    assign point_index = s_tdata[3*COORD_BITS+INDEX_BITS-1:3*COORD_BITS];

    obpf_cfg #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .box_height  (box_height),
        .yaw_sine    (yaw_sine),
        .yaw_cosine  (yaw_cosine),
        .len_lim     (len_lim),
        .wid_lim     (wid_lim),
        .len_nonzero (len_nonzero),
        .wid_nonzero (wid_nonzero)
    );

    obpf_rotate #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .INDEX_BITS     (INDEX_BITS)
    ) u_rotate (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_index (point_index),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .yaw_sine    (yaw_sine),
        .yaw_cosine  (yaw_cosine),
        .prod_valid  (prod_valid),
        .prod_ready  (prod_ready),
        .c_dx        (c_dx),
        .s_dy        (s_dy),
        .c_dy        (c_dy),
        .s_dx        (s_dx),
        .dz          (dz),
        .prod_index  (prod_index)
    );

    obpf_classify #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .INDEX_BITS     (INDEX_BITS)
    ) u_classify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .prod_valid  (prod_valid),
        .prod_ready  (prod_ready),
        .c_dx        (c_dx),
        .s_dy        (s_dy),
        .c_dy        (c_dy),
        .s_dx        (s_dx),
        .dz          (dz),
        .prod_index  (prod_index),
        .box_height  (box_height),
        .len_lim     (len_lim),
        .wid_lim     (wid_lim),
        .len_nonzero (len_nonzero),
        .wid_nonzero (wid_nonzero),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .index_out   (index_out),
        .in_box      (in_box)
    );

    // pack the result
    assign m_tdata = OUT_W'({in_box, index_out});

endmodule
